### design/converter_output_hysteresis_control_core_assert.svh
// Assertion macros for the converter output hysteresis control core.
// Used by the port checker; needs a clock i_clk and reset i_rst_n in scope.
`ifndef CONVERTER_OUTPUT_HYSTERESIS_CONTROL_CORE_ASSERT_SVH
`define CONVERTER_OUTPUT_HYSTERESIS_CONTROL_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define COHC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cohc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define COHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cohc assertion failed");

`endif

### design/cohc_pkg.sv
// Shared types and constants of the converter output hysteresis control core.
// Used by every module of the block but the checker; depends on nothing.
package cohc_pkg;

    // Field and bus widths.
    localparam int STORAGE_W  = 24;
    localparam int INTERVAL_W = 20;
    localparam int CONTROL_W  = 22;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 56;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_CONTROL     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE_THR  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DISABLE_THR = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE_DROP = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PG_HI_THR   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PG_LO_THR   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_OUT  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BUCK_DROP   = 3'd7;

    // Bit positions inside the control register.
    localparam int BUCK_BIT      = 20;
    localparam int IMMEDIATE_BIT = 21;

    // Decoded configuration.
    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic                  buck_en;
        logic                  immediate;
        logic [STORAGE_W-1:0]  enable_thr;
        logic [STORAGE_W-1:0]  disable_thr;
        logic [STORAGE_W-1:0]  enable_drop;
        logic [STORAGE_W-1:0]  pg_hi_thr;
        logic [STORAGE_W-1:0]  pg_lo_thr;
        logic [STORAGE_W-1:0]  target_out;
        logic [STORAGE_W-1:0]  buck_drop;
    } t_cfg;

    // One input sample.
    typedef struct packed {
        logic [STORAGE_W-1:0] storage_uv;
        logic                 startup_drain_active;
    } t_in_item;

    // Decision of the hysteresis control for the sample at hand.
    typedef struct packed {
        logic check;
        logic enabled;
        logic turn_on;
    } t_ctrl_status;

    // One result item.
    typedef struct packed {
        logic [STORAGE_W-1:0] out_voltage_uv;
        logic                 pgood_written;
        logic [1:0]           pgood_bits;
        logic                 output_on;
        logic [STORAGE_W-1:0] new_storage_uv;
    } t_result;

endpackage

### design/converter_output_hysteresis_control_core.sv
// Top level of the converter output hysteresis control core.
// Depends on cohc_pkg, cohc_regs, cohc_ctrl and cohc_volt.
//
// Takes one storage voltage sample per request on the slave stream and returns
// one result per sample on the master stream. A sample is captured in an input
// register, evaluated combinationally by the sample counter, hysteresis flag
// and voltage logic, and lands in the result register; a new sample can be
// taken every cycle while the result stream does not stall, as the counter and
// the enable flag update whenever a sample passes. The first sample after reset
// is a check sample unless the interval is set above the counter's reset value
// plus one. Configuration is to be written through the plain write port only
// while the stream is idle; the block itself does not enforce this.
module converter_output_hysteresis_control_core #(
    parameter int COUNTER_BITS = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [cohc_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  logic [cohc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Sample stream.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // Fields from bit 0: storage_uv[23:0], startup_drain_active[24], zero pad.
    input  logic [cohc_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // Result stream.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // Fields from bit 0: new_storage_uv[23:0], output_on[24], pgood_bits[26:25],
    // pgood_written[27], out_voltage_uv[51:28], zero pad.
    output logic [cohc_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import cohc_pkg::*;

    t_cfg         cfg;
    t_ctrl_status status;
    t_result      result;
    t_in_item     r_in;
    t_result      r_out;
    logic         r_in_valid;
    logic         r_out_valid;
    logic         advance;
    logic         s_take;

    // Handshake: the input stage drains whenever the result register is free.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_take     = i_s_tvalid && o_s_tready;

    cohc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cohc_ctrl #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_storage_uv (r_in.storage_uv),
        .i_cfg        (cfg),
        .o_status     (status)
    );

    cohc_volt u_volt (
        .i_item   (r_in),
        .i_cfg    (cfg),
        .i_status (status),
        .o_result (result)
    );

    // Valid flags of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in.storage_uv           <= i_s_tdata[STORAGE_W-1:0];
            r_in.startup_drain_active <= i_s_tdata[STORAGE_W];
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - $bits(t_result)){1'b0}}, r_out};

endmodule

### design/cohc_regs.sv
// Configuration register file of the hysteresis control core.
// Depends on cohc_pkg for register indexes and the decoded configuration type.
module cohc_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cohc_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  logic [cohc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output cohc_pkg::t_cfg                   o_cfg
);
    import cohc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode a write into the addressed field, masked to the register width.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CONTROL: begin
                    n_cfg.interval  = i_cfg_data[INTERVAL_W-1:0];
                    n_cfg.buck_en   = i_cfg_data[BUCK_BIT];
                    n_cfg.immediate = i_cfg_data[IMMEDIATE_BIT];
                end
                REG_ENABLE_THR:  n_cfg.enable_thr  = i_cfg_data[STORAGE_W-1:0];
                REG_DISABLE_THR: n_cfg.disable_thr = i_cfg_data[STORAGE_W-1:0];
                REG_ENABLE_DROP: n_cfg.enable_drop = i_cfg_data[STORAGE_W-1:0];
                REG_PG_HI_THR:   n_cfg.pg_hi_thr   = i_cfg_data[STORAGE_W-1:0];
                REG_PG_LO_THR:   n_cfg.pg_lo_thr   = i_cfg_data[STORAGE_W-1:0];
                REG_TARGET_OUT:  n_cfg.target_out  = i_cfg_data[STORAGE_W-1:0];
                REG_BUCK_DROP:   n_cfg.buck_drop   = i_cfg_data[STORAGE_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    // All registers clear to zero on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/cohc_ctrl.sv
// Sample counter and hysteresis output-enable state of the control core.
// Depends on cohc_pkg for the configuration and status types.
module cohc_ctrl #(
    parameter int COUNTER_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic [cohc_pkg::STORAGE_W-1:0]  i_storage_uv,
    input  cohc_pkg::t_cfg                  i_cfg,
    output cohc_pkg::t_ctrl_status          o_status
);
    import cohc_pkg::*;

    localparam int CMP_W = (COUNTER_BITS > INTERVAL_W) ? COUNTER_BITS : INTERVAL_W;
    // All ones minus fifteen, so the first sample is a check unless the interval exceeds its increment.
    localparam logic [COUNTER_BITS-1:0] CNT_RST = ~COUNTER_BITS'(15);

    logic [COUNTER_BITS-1:0] r_cnt;
    logic [COUNTER_BITS-1:0] n_cnt;
    logic                    r_enabled;
    logic [COUNTER_BITS-1:0] cnt_inc;
    logic [CMP_W-1:0]        cnt_ext;
    logic [CMP_W-1:0]        interval_ext;
    logic [STORAGE_W-1:0]    enable_thr_eff;
    logic                    check;
    logic                    reach_on;
    logic                    fall_off;

    // Check decision: wrapped increment compared with the interval.
    assign cnt_inc      = r_cnt + COUNTER_BITS'(1);
    assign cnt_ext      = CMP_W'(cnt_inc);
    assign interval_ext = CMP_W'(i_cfg.interval);
    assign check        = (cnt_ext >= interval_ext);
    assign n_cnt        = check ? '0 : cnt_inc;

    // The enable threshold is never below the turn-on drop.
    assign enable_thr_eff = (i_cfg.enable_drop > i_cfg.enable_thr) ?
                            i_cfg.enable_drop : i_cfg.enable_thr;
    assign reach_on = (i_storage_uv >= enable_thr_eff);
    assign fall_off = (i_storage_uv < i_cfg.disable_thr);

    // Hysteresis decision for this sample.
    always_comb begin
        o_status.check   = check;
        o_status.turn_on = check && !r_enabled && reach_on;
        if (!check) begin
            o_status.enabled = r_enabled;
        end else if (r_enabled) begin
            o_status.enabled = !fall_off;
        end else begin
            o_status.enabled = reach_on;
        end
    end

    // State moves only when a sample passes to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= CNT_RST;
            r_enabled <= 1'b0;
        end else if (i_advance) begin
            r_cnt     <= n_cnt;
            r_enabled <= o_status.enabled;
        end
    end

endmodule

### design/cohc_volt.sv
// Voltage datapath: turn-on drop, power-good bits and output DAC voltage.
// Depends on cohc_pkg for the configuration, status and result types.
module cohc_volt (
    input  cohc_pkg::t_in_item      i_item,
    input  cohc_pkg::t_cfg          i_cfg,
    input  cohc_pkg::t_ctrl_status  i_status,
    output cohc_pkg::t_result       o_result
);
    import cohc_pkg::*;

    logic [STORAGE_W-1:0] v;
    logic [STORAGE_W:0]   buck_limit;
    logic                 written;
    logic                 driven;

    assign v          = i_item.storage_uv;
    assign buck_limit = {1'b0, i_cfg.target_out} + {1'b0, i_cfg.buck_drop};
    assign written    = i_status.check || i_cfg.immediate;
    assign driven     = i_status.enabled || i_item.startup_drain_active;

    always_comb begin
        // Storage after the fast-charge drop, saturating at zero.
        if (i_status.turn_on) begin
            o_result.new_storage_uv = (v > i_cfg.enable_drop) ? (v - i_cfg.enable_drop) : '0;
        end else begin
            o_result.new_storage_uv = v;
        end

        o_result.output_on     = i_status.enabled;
        o_result.pgood_written = written;

        // Power-good bits use the voltage before the drop.
        if (written && i_status.enabled) begin
            o_result.pgood_bits = {(v >= i_cfg.pg_hi_thr), (v > i_cfg.pg_lo_thr)};
        end else begin
            o_result.pgood_bits = 2'b00;
        end

        // Output DAC: zero when not driven, else buck-regulated, or storage minus the buck drop.
        if (!driven) begin
            o_result.out_voltage_uv = '0;
        end else if (!i_cfg.buck_en || ({1'b0, v} <= buck_limit)) begin
            o_result.out_voltage_uv = (v > i_cfg.buck_drop) ? (v - i_cfg.buck_drop) : '0;
        end else begin
            o_result.out_voltage_uv = i_cfg.target_out;
        end
    end

endmodule

### design/cohc_checker.sv
// Port-level checker of the hysteresis control core, bound to the top level.
// Depends on the assertion macro header.
`include "converter_output_hysteresis_control_core_assert.svh"

module cohc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata
);

    // Power-good bits stay clear when they were not written.
    `COHC_ASSERT_SAME(a_pgood_unwritten, o_m_tvalid && !o_m_tdata[27], o_m_tdata[26:25] == 2'b00)

    // Power-good bits stay clear while the output is off.
    `COHC_ASSERT_SAME(a_pgood_off, o_m_tvalid && !o_m_tdata[24], o_m_tdata[26:25] == 2'b00)

    // An empty result register never stalls the sample stream.
    `COHC_ASSERT_SAME(a_ready_when_empty, !o_m_tvalid, o_s_tready)

    // A stalled result holds its value.
    `COHC_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

endmodule

bind converter_output_hysteresis_control_core cohc_checker u_checker (.*);
